// ----- rtl/core/mandelbrot_escape_time_unit_macros.svh -----
// Assertion macros for the escape-time unit.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MET_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("escape-time unit check failed");

// Antecedent implies consequent in the next cycle.
`define MET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("escape-time unit check failed");

`endif

// ----- rtl/core/met_pkg.sv -----
// Shared types, constants and fixed-point helpers of the escape-time unit.
`default_nettype none
package met_pkg;

  localparam int WORD_WIDTH  = 32;
  localparam int FRAC_BITS   = 28;
  localparam int IN_WIDTH    = 32;
  localparam int IN_FRAC     = 28;
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  localparam int PROD_W = 2 * WORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CONV_W = IN_WIDTH + WORD_WIDTH + FRAC_BITS;
  localparam int UP_SHIFT = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
  localparam int DN_SHIFT = (FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MODE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_START_RE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_START_IM   = CFG_IDX_W'(3);

  localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(100);
  localparam logic                   MODE_BOX    = 1'b0;
  localparam logic                   MODE_CIRCLE = 1'b1;

  localparam logic signed [WORD_WIDTH-1:0] BOX_LIMIT =
    WORD_WIDTH'(2) << FRAC_BITS;
  localparam logic [PROD_W:0] CIRCLE_LIMIT = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

  localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]         limit;
    logic                           mode;
    logic signed [IN_WIDTH-1:0]     start_re;
    logic signed [IN_WIDTH-1:0]     start_im;
  } met_cfg_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic upd_en;
  } met_cmd_t;

  typedef struct packed {
    logic escaped;
  } met_status_t;

  function automatic logic signed [WORD_WIDTH-1:0] sat_sum(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [WORD_WIDTH-1:0] r;
    if (v > SUM_W'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < SUM_W'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WORD_WIDTH-1:0] to_word(
    input logic signed [IN_WIDTH-1:0] v
  );
    logic signed [CONV_W-1:0] w;
    logic signed [WORD_WIDTH-1:0] r;
    w = CONV_W'(v);
    w = (w <<< UP_SHIFT) >>> DN_SHIFT;
    if (w > CONV_W'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (w < CONV_W'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = w[WORD_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_full(
    input logic signed [WORD_WIDTH-1:0] a,
    input logic signed [WORD_WIDTH-1:0] b
  );
    return PROD_W'(a) * PROD_W'(b);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mandelbrot_escape_time_unit.sv -----
// Top level of the escape-time unit: configuration registers, controller and datapath.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid_i / in_stall_o   c_re_i, c_im_i
//   out       source     out_valid_o / out_stall_i escape_count_o, inside_set_o
//   cfg       sink       cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// After acceptance a point runs one multiply state and one update-and-test state per
// step, n+1 steps in all, n being the updates done (escape step plus one, or
// iteration_limit), as set by the shared three-multiplier datapath.
// A point is accepted while the previous result word still waits at the output.
// Reset restores the register defaults and empties the output; no clearing pass.
// A stalled result holds the final step until the output register frees.
`default_nettype none
module mandelbrot_escape_time_unit import met_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [IN_WIDTH-1:0] c_re_i,
  input  wire logic signed [IN_WIDTH-1:0] c_im_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [COUNT_WIDTH-1:0]          escape_count_o,
  output logic                            inside_set_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata_i
);

  met_cfg_t    cfg_q;
  met_cmd_t    cmd;
  met_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit    <= LIMIT_RESET;
      cfg_q.mode     <= MODE_CIRCLE;
      cfg_q.start_re <= '0;
      cfg_q.start_im <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ITER_LIMIT: cfg_q.limit    <= cfg_wdata_i[COUNT_WIDTH-1:0];
        REG_BOUND_MODE: cfg_q.mode     <= cfg_wdata_i[0];
        REG_START_RE:   cfg_q.start_re <= cfg_wdata_i[IN_WIDTH-1:0];
        REG_START_IM:   cfg_q.start_im <= cfg_wdata_i[IN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  met_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .escape_count_o (escape_count_o),
    .inside_set_o   (inside_set_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  met_dp u_dp (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .c_re_i   (c_re_i),
    .c_im_i   (c_im_i),
    .status_o (status)
  );

endmodule
`default_nettype wire

// ----- rtl/core/met_dp.sv -----
// Datapath: holds z and c, forms the products, the update and the escape test.
`default_nettype none
module met_dp import met_pkg::*; (
  input  wire logic                       clk_i,
  input  wire met_cfg_t                   cfg_i,
  input  wire met_cmd_t                   cmd_i,
  input  wire logic signed [IN_WIDTH-1:0] c_re_i,
  input  wire logic signed [IN_WIDTH-1:0] c_im_i,
  output met_status_t                     status_o
);

  logic signed [WORD_WIDTH-1:0] c_re_q, c_im_q;
  logic signed [WORD_WIDTH-1:0] z_re_q, z_im_q;
  logic signed [PROD_W-1:0]     rr_q, ii_q, ri_q;

  logic signed [SUM_W-1:0]      re_sum, im_sum;
  logic signed [WORD_WIDTH-1:0] re_next, im_next;
  logic [PROD_W:0]              sq_sum;
  logic                         box_out, circle_out;

  always_comb begin
    re_sum  = ((SUM_W'(rr_q) - SUM_W'(ii_q)) >>> FRAC_BITS) + SUM_W'(c_re_q);
    im_sum  = (SUM_W'(ri_q) >>> (FRAC_BITS - 1)) + SUM_W'(c_im_q);
    re_next = sat_sum(re_sum);
    im_next = sat_sum(im_sum);
  end

  always_comb begin
    sq_sum     = (PROD_W + 1)'($unsigned(rr_q)) + (PROD_W + 1)'($unsigned(ii_q));
    circle_out = sq_sum > CIRCLE_LIMIT;
    box_out    = (z_re_q > BOX_LIMIT) || (z_re_q < -BOX_LIMIT) ||
                 (z_im_q > BOX_LIMIT) || (z_im_q < -BOX_LIMIT);
    status_o.escaped = (cfg_i.mode == MODE_CIRCLE) ? circle_out : box_out;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_re_q <= to_word(c_re_i);
      c_im_q <= to_word(c_im_i);
      z_re_q <= to_word(cfg_i.start_re);
      z_im_q <= to_word(cfg_i.start_im);
    end else if (cmd_i.upd_en) begin
      z_re_q <= re_next;
      z_im_q <= im_next;
    end
    if (cmd_i.mul_en) begin
      rr_q <= mul_full(z_re_q, z_re_q);
      ii_q <= mul_full(z_im_q, z_im_q);
      ri_q <= mul_full(z_re_q, z_im_q);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/met_ctrl.sv -----
// Controller: sequences the iterations, counts steps and holds the result word.
`default_nettype none
`include "mandelbrot_escape_time_unit_macros.svh"
module met_ctrl import met_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire met_cfg_t                cfg_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [COUNT_WIDTH-1:0]       escape_count_o,
  output logic                         inside_set_o,
  input  wire met_status_t             status_i,
  output met_cmd_t                     cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic [COUNT_WIDTH-1:0] result_q, result_d;
  logic                   inside_q, inside_d;
  logic                   can_load, hit, at_limit;

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = result_q;
  assign inside_set_o   = inside_q;

  assign can_load = !out_valid_q || !out_stall_i;
  assign hit      = (count_q != '0) && status_i.escaped;
  assign at_limit = (count_q == cfg_i.limit);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    result_d    = result_q;
    inside_d    = inside_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          count_d    = '0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_EVAL;
      end
      ST_EVAL: begin
        if (hit || at_limit) begin
          if (can_load) begin
            out_valid_d = 1'b1;
            result_d    = hit ? count_q - COUNT_WIDTH'(1) : cfg_i.limit;
            inside_d    = !hit;
            state_d     = ST_IDLE;
          end
        end else begin
          cmd_o.upd_en = 1'b1;
          count_d      = count_q + COUNT_WIDTH'(1);
          state_d      = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    inside_q <= inside_d;
  end

  `MET_ASSERT_NEXT(a_accept_starts, in_valid_i && !in_stall_o, state_q == ST_MUL)
  `MET_ASSERT_IMP(a_count_bound, state_q != ST_IDLE, count_q <= cfg_i.limit)
  `MET_ASSERT_IMP(a_inside_count, out_valid_q && inside_q, result_q == cfg_i.limit)
  `MET_ASSERT_IMP(a_escape_count, out_valid_q && !inside_q, result_q < cfg_i.limit)

endmodule
`default_nettype wire

// ----- sim/tb_mandelbrot_escape_time_unit.sv -----
// Self-checking testbench for the escape-time unit: directed and random points against a predictor.
`default_nettype none
module tb_mandelbrot_escape_time_unit import met_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXACT_W = 4 * WORD_WIDTH + 8;
  typedef logic signed [EXACT_W-1:0] exact_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic                   in_set;
  } escape_t;

  localparam logic signed [IN_WIDTH-1:0] Q_ZERO     = '0;
  localparam logic signed [IN_WIDTH-1:0] Q_TWO      = 32'sh2000_0000;
  localparam logic signed [IN_WIDTH-1:0] Q_NEG_TWO  = 32'shE000_0000;
  localparam logic signed [IN_WIDTH-1:0] Q_1P5      = 32'sh1800_0000;
  localparam logic signed [IN_WIDTH-1:0] Q_HALF     = 32'sh0800_0000;
  localparam logic signed [IN_WIDTH-1:0] Q_NEG_HALF = 32'shF800_0000;
  localparam logic signed [IN_WIDTH-1:0] Q_0P3      = 32'sh04CC_CCCC;
  localparam logic signed [IN_WIDTH-1:0] Q_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [IN_WIDTH-1:0] Q_MIN      = 32'sh8000_0000;
  localparam logic [CFG_IDX_W-1:0]       UNUSED_REG = 8'hA5;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [IN_WIDTH-1:0]    c_re_i = '0;
  logic signed [IN_WIDTH-1:0]    c_im_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [COUNT_WIDTH-1:0]        escape_count_o;
  logic                          inside_set_o;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i = '0;

  met_cfg_t shadow_cfg;
  escape_t  expected_escapes[$];
  int       mismatches = 0;
  int       stall_left = 0;
  int       hold_off = 0;
  bit       quiet = 1'b0;

  mandelbrot_escape_time_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .c_re_i         (c_re_i),
    .c_im_i         (c_im_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .escape_count_o (escape_count_o),
    .inside_set_o   (inside_set_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5ns clk_i = ~clk_i;

  function automatic exact_t clamp_to_word(input exact_t v);
    exact_t hi;
    exact_t lo;
    hi = (exact_t'(1) <<< (WORD_WIDTH - 1)) - exact_t'(1);
    lo = -hi - exact_t'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic exact_t scale_in(input logic signed [IN_WIDTH-1:0] v);
    exact_t w;
    w = exact_t'(v);
    if (FRAC_BITS >= IN_FRAC) begin
      w = w <<< (FRAC_BITS - IN_FRAC);
    end else begin
      w = w >>> (IN_FRAC - FRAC_BITS);
    end
    return clamp_to_word(w);
  endfunction

  function automatic escape_t predict_escape(input logic signed [IN_WIDTH-1:0] c_re,
                                             input logic signed [IN_WIDTH-1:0] c_im);
    exact_t  cr, ci, re, im, nre, nim, box, circ;
    escape_t r;
    bit      out_of_bounds;
    int      i;
    cr = scale_in(c_re);
    ci = scale_in(c_im);
    re = scale_in(shadow_cfg.start_re);
    im = scale_in(shadow_cfg.start_im);
    box = exact_t'(2) <<< FRAC_BITS;
    circ = exact_t'(4) <<< (2 * FRAC_BITS);
    r.count = shadow_cfg.limit;
    r.in_set = 1'b1;
    for (i = 0; i < int'(shadow_cfg.limit) && r.in_set; i++) begin
      nre = clamp_to_word(((re * re - im * im) >>> FRAC_BITS) + cr);
      nim = clamp_to_word(((re * im) >>> (FRAC_BITS - 1)) + ci);
      re = nre;
      im = nim;
      if (shadow_cfg.mode == MODE_BOX) begin
        out_of_bounds = re > box || re < -box || im > box || im < -box;
      end else begin
        out_of_bounds = (re * re + im * im) > circ;
      end
      if (out_of_bounds) begin
        r.count = COUNT_WIDTH'(i);
        r.in_set = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void random_point(output logic signed [IN_WIDTH-1:0] re,
                                       output logic signed [IN_WIDTH-1:0] im);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      re = $urandom_range(0, 805306368) - 603979776;
      im = $urandom_range(0, 805306368) - 402653184;
    end else if (r < 85) begin
      case ($urandom_range(0, 4))
        0:       begin re = -201326592; im = 26843546;  end
        1:       begin re = 67108864;   im = 0;         end
        2:       begin re = -335544320; im = 0;         end
        3:       begin re = -26843546;  im = 174483046; end
        default: begin re = 75161928;   im = 142270791; end
      endcase
      re = re + $urandom_range(0, 2097152) - 1048576;
      im = im + $urandom_range(0, 2097152) - 1048576;
      if ($urandom_range(0, 1)) im = -im;
    end else begin
      re = $urandom;
      im = $urandom;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ITER_LIMIT: shadow_cfg.limit = data[COUNT_WIDTH-1:0];
      REG_BOUND_MODE: shadow_cfg.mode = data[0];
      REG_START_RE:   shadow_cfg.start_re = data[IN_WIDTH-1:0];
      REG_START_IM:   shadow_cfg.start_im = data[IN_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic offer_point(input logic signed [IN_WIDTH-1:0] re,
                             input logic signed [IN_WIDTH-1:0] im);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    c_re_i <= re;
    c_im_i <= im;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    expected_escapes.push_back(predict_escape(re, im));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_escapes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic offer_random(input int count);
    logic signed [IN_WIDTH-1:0] re, im;
    repeat (count) begin
      random_point(re, im);
      offer_point(re, im);
    end
  endtask

  // Defaults after reset: circle test, limit 100, start at the origin.
  task automatic test_reset_defaults();
    offer_point(Q_ZERO, Q_ZERO);
    offer_point(Q_NEG_TWO, Q_ZERO);
    offer_point(Q_TWO, Q_ZERO);
    offer_point(Q_1P5, Q_1P5);
    offer_point(Q_MAX, Q_MAX);
    offer_point(Q_MIN, Q_MIN);
    drain();
  endtask

  task automatic test_box_mode();
    write_reg(REG_BOUND_MODE, CFG_DATA_W'(MODE_BOX));
    write_reg(REG_ITER_LIMIT, 32'd20);
    offer_point(Q_ZERO, Q_TWO);
    offer_point(Q_1P5, Q_1P5);
    offer_point(Q_TWO + 1, Q_ZERO);
    offer_point(Q_ZERO, Q_NEG_TWO - 1);
    offer_point(Q_NEG_TWO, Q_NEG_TWO);
    drain();
  endtask

  task automatic test_start_value();
    write_reg(REG_BOUND_MODE, CFG_DATA_W'(MODE_CIRCLE));
    write_reg(REG_ITER_LIMIT, 32'd100);
    write_reg(REG_START_RE, Q_MAX);
    write_reg(REG_START_IM, Q_MIN);
    offer_point(Q_ZERO, Q_ZERO);
    drain();
    write_reg(REG_START_RE, Q_MIN);
    write_reg(REG_START_IM, Q_MAX);
    offer_point(Q_MIN, Q_MIN);
    drain();
    write_reg(REG_START_RE, Q_HALF);
    write_reg(REG_START_IM, Q_HALF);
    offer_point(Q_NEG_HALF, Q_ZERO);
    drain();
    // ignore unknown indexes and bits above the limit and mode registers' widths
    write_reg(UNUSED_REG, $urandom);
    write_reg(REG_ITER_LIMIT, 32'hFFFF_0003);
    write_reg(REG_BOUND_MODE, 32'hFFFF_FFFE);
    write_reg(REG_START_RE, '0);
    write_reg(REG_START_IM, '0);
    offer_point(Q_ZERO, Q_ZERO);
    drain();
  endtask

  task automatic test_limit_extremes();
    write_reg(REG_ITER_LIMIT, 32'd0);
    offer_point(Q_ZERO, Q_ZERO);
    offer_point(Q_MAX, Q_MIN);
    drain();
    write_reg(REG_ITER_LIMIT, 32'd1);
    offer_point(Q_1P5, Q_1P5);
    drain();
    write_reg(REG_BOUND_MODE, CFG_DATA_W'(MODE_CIRCLE));
    write_reg(REG_ITER_LIMIT, 32'h0000_FFFF);
    offer_point(Q_ZERO, Q_ZERO);
    offer_point(Q_0P3, Q_ZERO);
    drain();
  endtask

  task automatic test_input_pressure();
    write_reg(REG_ITER_LIMIT, 32'd8);
    quiet = 1'b1;
    hold_off = 400;
    offer_random(30);
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_random_phases();
    logic [COUNT_WIDTH-1:0] limit;
    logic [IN_WIDTH-1:0]    start_re, start_im;
    int                     r;
    for (int phase = 0; phase < 8; phase++) begin
      r = $urandom_range(0, 9);
      if (r < 5) limit = COUNT_WIDTH'($urandom_range(1, 40));
      else if (r < 8) limit = COUNT_WIDTH'($urandom_range(41, 120));
      else limit = COUNT_WIDTH'($urandom_range(121, 250));
      r = $urandom_range(0, 9);
      if (r < 5) begin
        start_re = '0;
        start_im = '0;
      end else if (r < 8) begin
        start_re = $urandom_range(0, 268435456) - 134217728;
        start_im = $urandom_range(0, 268435456) - 134217728;
      end else begin
        start_re = $urandom;
        start_im = $urandom;
      end
      write_reg(REG_ITER_LIMIT, ($urandom & 32'hFFFF_0000) | CFG_DATA_W'(limit));
      write_reg(REG_BOUND_MODE, ($urandom & ~32'h1) | CFG_DATA_W'(phase[0]));
      write_reg(REG_START_RE, start_re);
      write_reg(REG_START_IM, start_im);
      quiet = (phase == 3);
      offer_random(210);
      quiet = 1'b0;
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!quiet) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    escape_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_escapes.size() == 0) begin
        $display("%0t: result word with none expected: count %0d inside %0b",
                 $time, escape_count_o, inside_set_o);
        mismatches++;
      end else begin
        want = expected_escapes.pop_front();
        if (escape_count_o !== want.count) begin
          $display("%0t: escape_count expected %0d actual %0d",
                   $time, want.count, escape_count_o);
          mismatches++;
        end
        if (inside_set_o !== want.in_set) begin
          $display("%0t: inside_set expected %0b actual %0b",
                   $time, want.in_set, inside_set_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    shadow_cfg.limit = LIMIT_RESET;
    shadow_cfg.mode = MODE_CIRCLE;
    shadow_cfg.start_re = '0;
    shadow_cfg.start_im = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_box_mode();
    test_start_value();
    test_limit_extremes();
    test_input_pressure();
    test_random_phases();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/met_pkg.sv
rtl/core/met_dp.sv
rtl/core/met_ctrl.sv
rtl/core/mandelbrot_escape_time_unit.sv
sim/tb_mandelbrot_escape_time_unit.sv
